FILE: design/slir_pkg.sv
package slir_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int VALUE_W    = 32;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int ENTRY_W    = 5;
   localparam int STATUS_W   = 2;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic                       operation;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic [ENTRY_W-1:0]         entry_count;
      logic signed [VALUE_W-1:0]  smallest;
      logic signed [VALUE_W-1:0]  largest;
   } rsp_type;

   // what one cell hands its neighbors
   typedef struct packed {
      logic                       valid;
      logic signed [VALUE_W-1:0]  value;
   } cell_link_type;

   // broadcast to all cells
   typedef struct packed {
      logic                       compare;
      logic                       apply;
      logic                       operation;
      logic signed [VALUE_W-1:0]  value;
      logic                       found;
      logic                       full;
   } cell_cmd_type;

endpackage

FILE: design/slir_cell.sv
module slir_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  slir_pkg::cell_cmd_type  cmd,
   input  slir_pkg::cell_link_type left_link,
   input  logic                    left_take,
   input  slir_pkg::cell_link_type right_link,
   output slir_pkg::cell_link_type link,
   output logic                    take,
   output logic                    eq
);
   import slir_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      ge_ff, ge_in;
   logic                      eq_ff, eq_in;

   // compare phase: flag entries at or above the operand
   always_comb begin
      ge_in = ge_ff;
      eq_in = eq_ff;
      if (cmd.compare) begin
         ge_in = valid_ff && !($signed(value_ff) < $signed(cmd.value));
         eq_in = valid_ff && (value_ff == cmd.value);
      end
   end

   assign take = !valid_ff || ge_ff;

   // apply phase: shift right on insert, shift left on remove
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.apply) begin
         if (cmd.operation == OP_INSERT) begin
            if (!cmd.full && take) begin
               value_in = left_take ? left_link.value : cmd.value;
               valid_in = valid_ff | left_link.valid;
            end
         end else begin
            if (cmd.found && ge_ff) begin
               value_in = right_link.value;
               valid_in = right_link.valid;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      ge_ff    <= ge_in;
      eq_ff    <= eq_in;
   end

   assign link.valid = valid_ff;
   assign link.value = value_ff;
   assign eq         = eq_ff;

endmodule

FILE: design/sorted_list_insert_remove_top.sv
// sorted list of signed 32-bit values held in a chain of LIST_DEPTH cells, ascending from
// cell 0. each req beat is an insert (placed in front of the first entry at or above it,
// rejected with a full status when the list is full) or a remove of one equal entry
// (not-found status when absent or when the list is empty). every beat gives one rsp beat
// with status, entry count and the first and last entries (zero when empty). an item goes
// through the accept, a compare phase where every cell flags itself against the
// operand, an apply phase where the cells shift one place toward or away from the
// insertion point, and a report phase that loads the rsp register. a new req beat is taken
// while a finished rsp beat still waits; the report phase holds only if the previous rsp
// beat has not been taken yet
module sorted_list_insert_remove_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  slir_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slir_pkg::rsp_type rsp_data
);
   import slir_pkg::*;

   // sequencer phases
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_COMPARE = 2'd1;
   localparam logic [1:0] PH_APPLY   = 2'd2;
   localparam logic [1:0] PH_REPORT  = 2'd3;

   logic [1:0]                phase_ff, phase_in;
   logic                      op_ff, op_in;
   logic signed [VALUE_W-1:0] operand_ff, operand_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   cell_cmd_type              cmd;
   cell_link_type             links [LIST_DEPTH];
   cell_link_type             lefts [LIST_DEPTH];
   cell_link_type             rights[LIST_DEPTH];
   logic [LIST_DEPTH-1:0]     takes;
   logic [LIST_DEPTH-1:0]     left_takes;
   logic [LIST_DEPTH-1:0]     eqs;
   logic [LIST_DEPTH-1:0]     valids;

   logic                      full;
   logic                      found;
   logic signed [VALUE_W-1:0] last_value;
   logic                      req_fire;
   logic                      rsp_free;

   assign req_ready = (phase_ff == PH_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign full  = (count_ff == CNT_W'(LIST_DEPTH));
   assign found = |eqs;

   assign cmd.compare   = (phase_ff == PH_COMPARE);
   assign cmd.apply     = (phase_ff == PH_APPLY);
   assign cmd.operation = op_ff;
   assign cmd.value     = operand_ff;
   assign cmd.found     = found;
   assign cmd.full      = full;

   // the chain: each cell sees its left and right neighbor
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign lefts[i]      = '{valid: 1'b1, value: '0};
         assign left_takes[i] = 1'b0;
      end else begin : g_body
         assign lefts[i]      = links[i-1];
         assign left_takes[i] = takes[i-1];
      end
      if (i == LIST_DEPTH - 1) begin : g_tail
         assign rights[i] = '{valid: 1'b0, value: '0};
      end else begin : g_inner
         assign rights[i] = links[i+1];
      end

      slir_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (lefts[i]),
         .left_take  (left_takes[i]),
         .right_link (rights[i]),
         .link       (links[i]),
         .take       (takes[i]),
         .eq         (eqs[i])
      );

      assign valids[i] = links[i].valid;
   end

   // last occupied cell picked out by its empty right neighbor
   always_comb begin
      last_value = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (links[i].valid && !rights[i].valid) begin
            last_value = last_value | links[i].value;
         end
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      operand_in   = operand_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_fire) begin
               op_in      = req_data.operation;
               operand_in = req_data.value;
               phase_in   = PH_COMPARE;
            end
         end
         PH_COMPARE: begin
            phase_in = PH_APPLY;
         end
         PH_APPLY: begin
            if (op_ff == OP_INSERT) begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_DONE;
                  count_in  = count_ff + CNT_W'(1);
               end
            end else begin
               if (found) begin
                  status_in = ST_DONE;
                  count_in  = count_ff - CNT_W'(1);
               end else begin
                  status_in = ST_MISSING;
               end
            end
            phase_in = PH_REPORT;
         end
         PH_REPORT: begin
            if (rsp_free) begin
               rsp_in.status      = status_ff;
               rsp_in.entry_count = ENTRY_W'(count_ff);
               rsp_in.smallest    = links[0].valid ? links[0].value : '0;
               rsp_in.largest     = last_value;
               rsp_valid_in       = 1'b1;
               phase_in           = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      operand_ff <= operand_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupied cells form a prefix; this checks that their number always matches the count
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valids) == int'(count_ff))
      else $error("cell occupancy differs from entry count");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count above list depth");

   a_full_insert_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_APPLY && op_ff == OP_INSERT && full) |=> $stable(count_ff))
      else $error("rejected insert changed the count");

   a_missing_status: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_APPLY && op_ff == OP_REMOVE && !found) |=> status_ff == ST_MISSING)
      else $error("remove of absent value not reported");

endmodule
